[design/kufa_pkg.sv]
`timescale 1ns / 1ps

package kufa_pkg;

   // Forest size and the derived width of a table address.
   localparam int NODES   = 128;
   localparam int NODE_AW = (NODES > 1) ? $clog2(NODES) : 1;

   // Fixed field widths of the channels.
   localparam int NODE_W = 7;
   localparam int COEF_W = 32;
   localparam int SUM_W  = 40;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHK_U  = 5'b00010,
      ST_CHK_V  = 5'b00100,
      ST_UPDATE = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   function automatic logic [SUM_W-1:0] sext_coef(input logic [COEF_W-1:0] c);
      return {{(SUM_W-COEF_W){c[COEF_W-1]}}, c};
   endfunction

endpackage

[design/kufa_ram.sv]
`timescale 1ns / 1ps

module kufa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/kruskal_union_find_accumulator.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   node_u, node_v, coef_quad/lin/const, last_edge
// rsp       out        rsp_valid/rsp_ready   joined, total_quad/lin/const, final_flag
//
// An edge walks up from node_u and then from node_v to their roots, du and dv links,
// the depths of the two endpoints in the forest; the parent table has one read port
// with a registered read, so the root walk follows one parent link at a time. The
// sequencer returns to idle after each edge and only then takes the next transfer.
// Reset clears the sequencer, the sums and the per-entry valid bits of the parent
// table at once; an entry that is not valid reads as pointing to itself.
// req_ready is high only while the sequencer is idle; a result waiting in the
// output register stalls the sequencer only when the next result is ready to load.

module kruskal_union_find_accumulator
   import kufa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [NODE_W-1:0]        req_node_u,
   input  logic [NODE_W-1:0]        req_node_v,
   input  logic signed [COEF_W-1:0] req_coef_quad,
   input  logic signed [COEF_W-1:0] req_coef_lin,
   input  logic signed [COEF_W-1:0] req_coef_const,
   input  logic                     req_last_edge,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_joined,
   output logic signed [SUM_W-1:0]  rsp_total_quad,
   output logic signed [SUM_W-1:0]  rsp_total_lin,
   output logic signed [SUM_W-1:0]  rsp_total_const,
   output logic                     rsp_final_flag
);

   // Sequencer and the captured edge.
   state_type            state_ff, state_in;
   logic [NODE_AW-1:0]   cur_ff, cur_in;
   logic [NODE_AW-1:0]   node_v_ff, node_v_in;
   logic [NODE_AW-1:0]   root_u_ff, root_u_in;
   logic [COEF_W-1:0]    coef_quad_ff, coef_quad_in;
   logic [COEF_W-1:0]    coef_lin_ff, coef_lin_in;
   logic [COEF_W-1:0]    coef_const_ff, coef_const_in;
   logic                 last_ff, last_in;
   logic                 joined_ff, joined_in;

   // Running sums and the valid bits of the parent table.
   logic [SUM_W-1:0]     sum_quad_ff, sum_quad_in;
   logic [SUM_W-1:0]     sum_lin_ff, sum_lin_in;
   logic [SUM_W-1:0]     sum_const_ff, sum_const_in;
   logic [NODES-1:0]     valid_ff, valid_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_joined_ff, rsp_joined_in;
   logic [SUM_W-1:0]     rsp_quad_ff, rsp_quad_in;
   logic [SUM_W-1:0]     rsp_lin_ff, rsp_lin_in;
   logic [SUM_W-1:0]     rsp_const_ff, rsp_const_in;
   logic                 rsp_final_ff, rsp_final_in;

   // Parent table port.
   logic                 ram_we;
   logic [NODE_AW-1:0]   ram_rdata;
   logic [NODE_AW-1:0]   parent;
   logic                 at_root;
   logic                 in_range;
   logic                 req_xfer;
   logic                 out_free;

   kufa_ram #(
      .WIDTH (NODE_AW),
      .DEPTH (NODES)
   ) u_parent_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cur_ff),
      .wr_data (root_u_ff),
      .rd_addr (cur_in),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign in_range  = (32'(req_node_u) < NODES) && (32'(req_node_v) < NODES);

   // The entry read last cycle belongs to cur_ff; a never-linked node is its own parent.
   assign parent  = valid_ff[cur_ff] ? ram_rdata : cur_ff;
   assign at_root = (parent == cur_ff);

   // In the update step cur_ff holds the root of node_v.
   assign ram_we = (state_ff == ST_UPDATE) && (root_u_ff != cur_ff);

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      node_v_in     = node_v_ff;
      root_u_in     = root_u_ff;
      coef_quad_in  = coef_quad_ff;
      coef_lin_in   = coef_lin_ff;
      coef_const_in = coef_const_ff;
      last_in       = last_ff;
      joined_in     = joined_ff;
      sum_quad_in   = sum_quad_ff;
      sum_lin_in    = sum_lin_ff;
      sum_const_in  = sum_const_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_joined_in = rsp_joined_ff;
      rsp_quad_in   = rsp_quad_ff;
      rsp_lin_in    = rsp_lin_ff;
      rsp_const_in  = rsp_const_ff;
      rsp_final_in  = rsp_final_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cur_in        = NODE_AW'(req_node_u);
               node_v_in     = NODE_AW'(req_node_v);
               coef_quad_in  = req_coef_quad;
               coef_lin_in   = req_coef_lin;
               coef_const_in = req_coef_const;
               last_in       = req_last_edge;
               joined_in     = 1'b0;
               // An endpoint outside the forest rejects the edge without a walk.
               state_in      = in_range ? ST_CHK_U : ST_DONE;
            end
         end
         ST_CHK_U: begin
            if (at_root) begin
               root_u_in = cur_ff;
               cur_in    = node_v_ff;
               state_in  = ST_CHK_V;
            end else begin
               cur_in = parent;
            end
         end
         ST_CHK_V: begin
            if (at_root) begin
               state_in = ST_UPDATE;
            end else begin
               cur_in = parent;
            end
         end
         ST_UPDATE: begin
            if (root_u_ff != cur_ff) begin
               valid_in[cur_ff] = 1'b1;
               sum_quad_in      = sum_quad_ff + sext_coef(coef_quad_ff);
               sum_lin_in       = sum_lin_ff + sext_coef(coef_lin_ff);
               sum_const_in     = sum_const_ff + sext_coef(coef_const_ff);
               joined_in        = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_joined_in = joined_ff;
               rsp_quad_in   = sum_quad_ff;
               rsp_lin_in    = sum_lin_ff;
               rsp_const_in  = sum_const_ff;
               rsp_final_in  = last_ff;
               // The last edge of a graph starts a fresh forest and fresh sums.
               if (last_ff) begin
                  valid_in     = '0;
                  sum_quad_in  = '0;
                  sum_lin_in   = '0;
                  sum_const_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         sum_quad_ff  <= '0;
         sum_lin_ff   <= '0;
         sum_const_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         sum_quad_ff  <= sum_quad_in;
         sum_lin_ff   <= sum_lin_in;
         sum_const_ff <= sum_const_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      node_v_ff     <= node_v_in;
      root_u_ff     <= root_u_in;
      coef_quad_ff  <= coef_quad_in;
      coef_lin_ff   <= coef_lin_in;
      coef_const_ff <= coef_const_in;
      last_ff       <= last_in;
      joined_ff     <= joined_in;
      rsp_joined_ff <= rsp_joined_in;
      rsp_quad_ff   <= rsp_quad_in;
      rsp_lin_ff    <= rsp_lin_in;
      rsp_const_ff  <= rsp_const_in;
      rsp_final_ff  <= rsp_final_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_joined      = rsp_joined_ff;
   assign rsp_total_quad  = rsp_quad_ff;
   assign rsp_total_lin   = rsp_lin_ff;
   assign rsp_total_const = rsp_const_ff;
   assign rsp_final_flag  = rsp_final_ff;

   // An accepted edge always occupies the sequencer for at least the next cycle.
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_ready)
      else $error("sequencer ready right after a transfer");

   // A new result appears only out of the final sequencer step.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside the final step");

   // A link is written only to a node that is not yet linked.
   a_link_once: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !valid_ff[cur_ff])
      else $error("root of node_v already has a parent");

   // Closing a graph leaves the forest and the sums cleared.
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free && last_ff) |=>
         (valid_ff == '0 && sum_quad_ff == '0 && sum_lin_ff == '0 && sum_const_ff == '0))
      else $error("state not cleared after the last edge");

endmodule
